// ----- rtl/hcb_pkg.sv -----
`default_nettype none
package hcb_pkg;
  localparam int unsigned MaxSymbolsDef = 8;
  localparam int unsigned FreqW         = 16;
  localparam int unsigned WeightW       = 19;
  localparam int unsigned CountW        = 4;
  localparam int unsigned IdxW          = 3;
  localparam int unsigned CodeW         = 7;
  localparam int unsigned LenW          = 3;
  localparam logic [CountW-1:0] CountReset = 4'd6;

  typedef enum logic [2:0] {
    StLoad,
    StPick,
    StMerge,
    StWalk,
    StEmit
  } hcb_state_e;
endpackage
`default_nettype wire

// ----- rtl/hcb_cell.sv -----
`default_nettype none
// One node cell of the chain. It holds a live node's weight and rank, and the
// per-leaf code being built. Each cycle it compares its own entry with the
// best candidate arriving from its left neighbour and registers the better one
// for its right neighbour.
module hcb_cell
  import hcb_pkg::*;
#(
  parameter int unsigned RankW = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic [WeightW-1:0] load_weight_i,
  input  wire logic [RankW-1:0]   load_rank_i,
  input  wire logic               kill_i,
  input  wire logic               code_clr_i,
  input  wire logic               code_push_i,
  input  wire logic               code_bit_i,
  input  wire logic               cand_valid_i,
  input  wire logic [WeightW-1:0] cand_weight_i,
  input  wire logic [RankW-1:0]   cand_rank_i,
  output logic                    cand_valid_o,
  output logic [WeightW-1:0]      cand_weight_o,
  output logic [RankW-1:0]        cand_rank_o,
  output logic                    live_o,
  output logic [RankW-1:0]        rank_o,
  output logic [CodeW-1:0]        code_o,
  output logic [LenW-1:0]         len_o
);
  logic               live_q;
  logic [WeightW-1:0] weight_q;
  logic [RankW-1:0]   rank_q;
  logic [CodeW-1:0]   code_q;
  logic [LenW-1:0]    len_q;
  logic               cand_valid_q;
  logic [WeightW-1:0] cand_weight_q;
  logic [RankW-1:0]   cand_rank_q;
  logic               mine;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= 1'b0;
      cand_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        live_q <= 1'b1;
      end else if (kill_i) begin
        live_q <= 1'b0;
      end
      cand_valid_q <= cand_valid_i | live_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      weight_q <= load_weight_i;
      rank_q   <= load_rank_i;
    end
    if (code_clr_i) begin
      code_q <= '0;
      len_q  <= '0;
    end else if (code_push_i) begin
      code_q <= code_q | (CodeW'(code_bit_i) << len_q);
      len_q  <= len_q + LenW'(1);
    end
    cand_weight_q <= mine ? weight_q : cand_weight_i;
    cand_rank_q   <= mine ? rank_q : cand_rank_i;
  end

  always_comb begin
    mine = live_q && (!cand_valid_i || weight_q < cand_weight_i ||
           (weight_q == cand_weight_i && rank_q < cand_rank_i));
  end

  assign cand_valid_o  = cand_valid_q;
  assign cand_weight_o = cand_weight_q;
  assign cand_rank_o   = cand_rank_q;
  assign live_o = live_q;
  assign rank_o = rank_q;
  assign code_o = code_q;
  assign len_o  = len_q;
endmodule
`default_nettype wire

// ----- rtl/huffman_code_builder_core.sv -----
`default_nettype none
// Channel      | Beat contents                                       | Direction
// s_axis       | tdata[15:0] frequency                               | in
// m_axis       | tdata[2:0] index, [9:3] code, [12:10] length; tlast | out
// cfg          | cfg_we_i / cfg_wdata_i: symbol_count                | in
// Loading accepts one frequency beat per cycle. Building the tree takes n-1 merges;
// each merge runs two selection passes down the registered cell chain, then writes
// the merged node into the next free cell. Codes then leave at one beat a cycle while
// m_axis_tready is high. The input is held off from the last load until the last beat.
// Reset clears control state only; a stalled beat holds steady.
module huffman_code_builder_core
  import hcb_pkg::*;
#(
  parameter int unsigned MaxSymbols = MaxSymbolsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,  // [15:0] frequency
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // [2:0] index, [9:3] code, [12:10] length
  output logic                   m_axis_tlast
);
  localparam int unsigned Nodes = 2 * MaxSymbols - 1;
  localparam int unsigned NodeW = $clog2(Nodes + 1);
  localparam int unsigned RankW = $clog2(Nodes + 2);
  localparam int unsigned SymW  = $clog2(MaxSymbols + 1);

  hcb_state_e state_q, state_d;
  logic [CountW-1:0] cnt_q;
  logic [SymW-1:0]   n;
  logic [SymW-1:0]   load_q;
  logic [NodeW-1:0]  next_q;
  logic [SymW-1:0]   emit_q;
  logic              second_q;
  logic [NodeW-1:0]  settle_q;
  logic              settled;
  logic [WeightW-1:0] wa_q;
  logic [RankW-1:0]   ra_q;
  logic [WeightW-1:0] wb_q;
  // group membership: which leaves lie under each node (bitmap per node)
  logic [MaxSymbols-1:0] grp_q [Nodes];

  logic               cv [Nodes+1];
  logic [WeightW-1:0] cw [Nodes+1];
  logic [RankW-1:0]   cr [Nodes+1];
  logic [Nodes-1:0]   live;
  logic [RankW-1:0]   nrank [Nodes];
  logic [CodeW-1:0]   code [Nodes];
  logic [LenW-1:0]    len  [Nodes];
  logic [Nodes-1:0]   kill, ld;
  logic [WeightW-1:0] ldw [Nodes];
  logic [RankW-1:0]   ldr [Nodes];
  logic [MaxSymbols-1:0] push;
  logic [NodeW-1:0] hit_q;
  logic [NodeW-1:0] hit_d;
  logic [MaxSymbols-1:0] grp_a_q;

  always_comb begin
    n = SymW'(cnt_q);
    if (cnt_q == '0) n = SymW'(1);
    if ({1'b0, cnt_q} > (CountW+1)'(MaxSymbols)) n = SymW'(MaxSymbols);
  end

  assign cv[0] = 1'b0;
  assign cw[0] = '0;
  assign cr[0] = '0;

  // The chain output is only trusted once a change has rippled through every cell.
  assign settled = (settle_q == NodeW'(Nodes));

  // locate the live node holding the chain winner (ranks are unique)
  always_comb begin
    hit_d = '0;
    for (int i = 0; i < Nodes; i++) begin
      if (live[i] && cr[Nodes] == nrank[i]) hit_d = NodeW'(i);
    end
  end

  for (genvar g = 0; g < Nodes; g++) begin : g_cell
    hcb_cell #(.RankW(RankW)) u_cell (
      .clk_i, .rst_ni,
      .load_i(ld[g]), .load_weight_i(ldw[g]), .load_rank_i(ldr[g]),
      .kill_i(kill[g]),
      .code_clr_i(state_q == StLoad && s_axis_tvalid && s_axis_tready && load_q == '0),
      .code_push_i(g < MaxSymbols ? push[g % MaxSymbols] : 1'b0),
      .code_bit_i(second_q),
      .cand_valid_i(cv[g]), .cand_weight_i(cw[g]), .cand_rank_i(cr[g]),
      .cand_valid_o(cv[g+1]), .cand_weight_o(cw[g+1]), .cand_rank_o(cr[g+1]),
      .live_o(live[g]), .rank_o(nrank[g]), .code_o(code[g]), .len_o(len[g])
    );
  end

  always_comb begin
    ld   = '0;
    kill = '0;
    push = '0;
    for (int i = 0; i < Nodes; i++) begin
      ldw[i] = '0;
      ldr[i] = '0;
    end
    if (state_q == StLoad && s_axis_tvalid) begin
      // The first beat of a job retires every node left over from the last one.
      if (load_q == '0) kill = '1;
      ld[load_q] = 1'b1;
      ldw[load_q] = WeightW'(s_axis_tdata);
      ldr[load_q] = RankW'(load_q) + RankW'(1);
    end
    if (state_q == StPick && settled) begin
      kill[hit_d] = 1'b1;
      push = grp_q[hit_d];
    end
    if (state_q == StMerge) begin
      ld[next_q] = 1'b1;
      ldw[next_q] = wa_q + wb_q;
      ldr[next_q] = ra_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad:  if (s_axis_tvalid && load_q == n - SymW'(1))
                 state_d = (n == SymW'(1)) ? StEmit : StPick;
      StPick:  if (settled && second_q) state_d = StMerge;
      StMerge: state_d = (next_q == NodeW'(2 * n - 2)) ? StEmit : StPick;
      StWalk:  state_d = StEmit;
      StEmit:  if (m_axis_tready && m_axis_tvalid && emit_q == n - SymW'(1))
                 state_d = StLoad;
      default: state_d = StLoad;
    endcase
    if (cfg_we_i) state_d = StLoad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      cnt_q    <= CountReset;
      load_q   <= '0;
      next_q   <= '0;
      emit_q   <= '0;
      second_q <= 1'b0;
      settle_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      case (state_q)
        StLoad: if (s_axis_tvalid) begin
          load_q   <= (load_q == n - SymW'(1)) ? '0 : load_q + SymW'(1);
          next_q   <= NodeW'(n);
          emit_q   <= '0;
          settle_q <= '0;
        end
        StPick: if (settled) begin
          second_q <= ~second_q;
          settle_q <= '0;
        end else begin
          settle_q <= settle_q + NodeW'(1);
        end
        StMerge: begin
          next_q   <= next_q + NodeW'(1);
          settle_q <= '0;
        end
        StEmit:  if (m_axis_tready) emit_q <= emit_q + SymW'(1);
        default: ;
      endcase
      if (cfg_we_i) begin
        load_q   <= '0;
        second_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (state_q == StLoad && s_axis_tvalid) begin
      grp_q[load_q] <= MaxSymbols'(1) << load_q;
    end
    if (state_q == StPick && settled && !second_q) begin
      wa_q <= cw[Nodes];
      ra_q <= cr[Nodes];
      grp_a_q <= grp_q[hit_d];
    end
    if (state_q == StPick && settled && second_q) begin
      wb_q <= cw[Nodes];
    end
    if (state_q == StMerge) grp_q[next_q] <= grp_a_q | grp_q[hit_q];
  end

  logic [SymW-1:0] ei;
  assign ei = emit_q;
  assign s_axis_tready = (state_q == StLoad);
  assign m_axis_tvalid = (state_q == StEmit);
  assign m_axis_tlast  = (emit_q == n - SymW'(1));
  assign m_axis_tdata  = {3'b0, len[ei], code[ei], IdxW'(ei)};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(s_axis_tready && m_axis_tvalid))
    else $error("load and emit overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid |-> (emit_q < n))
    else $error("emit index out of job");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StMerge) |-> $past(state_q == StPick))
    else $error("merge without pick");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && !m_axis_tready && !cfg_we_i) |=>
                   (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled beat changed");
endmodule
`default_nettype wire

// ----- bench/tb_huffman_code_builder_core.sv -----
`default_nettype none
module tb_huffman_code_builder_core;
  import hcb_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
    logic             lst;
  } code_beat_t;

  // Tracks the tree builder and holds the code beats still owed.
  class code_scoreboard;
    logic [CountW-1:0]  count_reg;
    int unsigned        loaded;
    logic [WeightW-1:0] wt[15];
    int unsigned        rk[15];
    int unsigned        par[15];
    bit                 side[15];
    bit                 live[15];
    code_beat_t         owed[$];
    int unsigned        errors;
    int unsigned        jobs;

    function new();
      count_reg = CountReset;
      loaded = 0;
      errors = 0;
      jobs = 0;
    endfunction

    function void set_count(logic [CountW-1:0] v);
      count_reg = v;
      loaded = 0;
    endfunction

    function int unsigned pick(int unsigned cnt);
      int unsigned best;
      best = cnt;
      for (int unsigned i = 0; i < cnt; i++) begin
        if (!live[i]) continue;
        if (best == cnt || wt[i] < wt[best] || (wt[i] == wt[best] && rk[i] < rk[best]))
          best = i;
      end
      return best;
    endfunction

    function void note_frequency(logic [FreqW-1:0] f);
      int unsigned n, nxt, a, b, node, len;
      logic [31:0] code;
      code_beat_t cb;
      n = (count_reg == 0) ? 1 : (count_reg > 8 ? 8 : count_reg);
      if (loaded >= n) loaded = 0;
      wt[loaded] = WeightW'(f);
      rk[loaded] = loaded + 1;
      loaded++;
      if (loaded < n) return;
      loaded = 0;
      jobs++;
      for (int i = 0; i < 15; i++) live[i] = (i < n);
      nxt = n;
      while (nxt < 2 * n - 1) begin
        a = pick(nxt); live[a] = 0;
        b = pick(nxt); live[b] = 0;
        wt[nxt] = wt[a] + wt[b];
        rk[nxt] = rk[a];
        live[nxt] = 1;
        par[a] = nxt; side[a] = 0;
        par[b] = nxt; side[b] = 1;
        nxt++;
      end
      for (int unsigned i = 0; i < n; i++) begin
        node = i; len = 0; code = 0;
        for (int g = 0; g < 15 && node != nxt - 1; g++) begin
          code |= 32'(side[node]) << len;
          len++;
          node = par[node];
        end
        cb.idx = i[IdxW-1:0];
        cb.code = code[CodeW-1:0];
        cb.len = len[LenW-1:0];
        cb.lst = (i == n - 1);
        owed = {owed, cb};
      end
    endfunction

    function void check_beat(logic [15:0] d, logic l);
      code_beat_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected code beat data=%h last=%b", $time, d, l);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (d[2:0] !== e.idx) begin
        $display("%0t: index expected %0d actual %0d", $time, e.idx, d[2:0]);
        errors++;
      end
      if (d[9:3] !== e.code) begin
        $display("%0t: code expected %b actual %b", $time, e.code, d[9:3]);
        errors++;
      end
      if (d[12:10] !== e.len) begin
        $display("%0t: length expected %0d actual %0d", $time, e.len, d[12:10]);
        errors++;
      end
      if (d[15:13] !== 3'b0) begin
        $display("%0t: pad bits expected 0 actual %b", $time, d[15:13]);
        errors++;
      end
      if (l !== e.lst) begin
        $display("%0t: last expected %b actual %b", $time, e.lst, l);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;

  code_scoreboard sb = new();
  bit quiet = 0;       // no idling in the final stretch
  bit hold_sink = 0;   // long receiver hold-off
  int unsigned idle_cycles = 0;
  int unsigned beats_seen = 0;

  always #1 clk_i = ~clk_i;

  huffman_code_builder_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_frequency(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tdata, m_axis_tlast);
      beats_seen++;
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 4000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall bursts, unless told to stay ready or to hold off.
  initial begin
    int unsigned k;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        k = $urandom_range(1, 12);
        repeat (k - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Leaves tvalid high on return so that beats can follow back to back.
  task automatic send_frequency(logic [15:0] f);
    int unsigned k;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      k = $urandom_range(1, 12);
      repeat (k) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_and_write(logic [CountW-1:0] v);
    s_axis_tvalid <= 0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.set_count(v);
  endtask

  task automatic random_job(int unsigned n);
    int unsigned mode;
    mode = $urandom_range(0, 3);
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        0: send_frequency(16'($urandom_range(0, 65535)));
        1: send_frequency(16'($urandom_range(0, 3)));
        2: send_frequency($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        default: send_frequency(16'(1 << $urandom_range(0, 15)));
      endcase
    end
  endtask

  initial begin
    int unsigned sent;
    logic [CountW-1:0] c;
    bit held;
    held = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: reset count of six, ties, extremes.
    for (int i = 0; i < 6; i++) send_frequency(16'd5);
    for (int i = 0; i < 6; i++) send_frequency(16'(16'hFFFF - i));
    drain_and_write(4'd1);             // single symbol
    send_frequency(16'h0000);
    send_frequency(16'hFFFF);
    drain_and_write(4'd8);             // deepest codes: skewed weights
    for (int i = 0; i < 8; i++) send_frequency(16'(1 << (2 * i)));
    drain_and_write(4'd0);             // zero count acts as one
    send_frequency(16'h1234);
    drain_and_write(4'd15);            // oversize count acts as eight
    send_frequency(16'hAAAA);
    send_frequency(16'h5555);
    drain_and_write(4'd2);             // drops the partial job above
    send_frequency(16'd7);
    send_frequency(16'd7);

    sent = 24;
    while (sent < 310) begin
      c = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) c = 4'(sent % 16);
      drain_and_write(c);
      repeat ($urandom_range(2, 5)) begin
        random_job((c == 0) ? 1 : (c > 8 ? 8 : c));
        sent += (c == 0) ? 1 : (c > 8 ? 8 : c);
        if ($urandom_range(0, 9) == 0) begin
          send_frequency(16'($urandom));    // stray beat, next job or dropped
          sent++;
        end
      end
      if (!held && sent > 150) begin
        // Receiver holds off while the sender keeps going.
        held = 1;
        hold_sink = 1;
        fork
          begin repeat (300) @(negedge clk_i); hold_sink = 0; end
          random_job(8);
        join
        s_axis_tvalid <= 0;
        sent += 8;
        while (sb.owed.size() != 0) @(negedge clk_i);
      end
      if (sent > 260) quiet = 1;
    end

    s_axis_tvalid <= 0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("Ran %0d jobs, %0d code beats, counts 0..15 incl. single symbol and ties.",
             sb.jobs, beats_seen);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
